// ===== sv/bdfmv_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and coefficient tables of the mesh velocity unit.
package bdfmv_pkg;

  localparam int POINTS    = 4096;
  localparam int AXES      = 3;
  localparam int HISTORY   = 3;
  localparam int MAX_ORDER = 3;

  localparam int ENTRIES = POINTS * AXES;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SLOT_W  = (HISTORY > 1) ? $clog2(HISTORY) : 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int COEF_W    = 17;
  localparam int COEF_FRAC = 14;
  localparam int PROD_W    = COEF_W + 32;
  localparam int ACC_W     = PROD_W + 2;
  localparam int D_W       = ACC_W - COEF_FRAC;
  localparam int MUL_W     = D_W + 17;
  localparam int VEL_FRAC  = 16;
  localparam int SUM_W     = MUL_W + VEL_FRAC + 1;
  localparam int V_W       = SUM_W - VEL_FRAC;

  localparam int PADDR_W = 3;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Backward difference coefficients, Q2.14, indexed by order minus one.
  localparam logic signed [COEF_W-1:0] GAMMA_Q14 [MAX_ORDER] = '{
    17'sd16384, 17'sd24576, 17'sd30037
  };
  localparam logic signed [COEF_W-1:0] ALPHA_Q14 [MAX_ORDER][MAX_ORDER] = '{
    '{17'sd16384, 17'sd0,      17'sd0},
    '{17'sd32768, -17'sd8192,  17'sd0},
    '{17'sd49152, -17'sd24576, 17'sd5461}
  };

  typedef enum logic {
    REG_BDF_ORDER    = 1'b0,
    REG_INV_TIMESTEP = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0]            coord;
    logic [MAX_ORDER-1:0][31:0]    lag;
    logic [1:0]                    ord;
    logic                          last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

endpackage

// ===== sv/bdfmv_if.sv =====
`timescale 1ns / 1ps
// Input and result channel interfaces of the mesh velocity unit.
interface bdfmv_in_if;
  logic               valid;
  logic               ready;
  logic [11:0]        point_index;
  logic [1:0]         axis;
  logic signed [31:0] rest_coord;
  logic signed [31:0] displacement;
  logic               last_in_step;

  modport source (output valid, point_index, axis, rest_coord, displacement, last_in_step,
                  input ready);
  modport sink (input valid, point_index, axis, rest_coord, displacement, last_in_step,
                output ready);
endinterface

interface bdfmv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_coord;
  logic signed [31:0] velocity;
  logic               step_end;

  modport source (output valid, new_coord, velocity, step_end, input ready);
  modport sink (input valid, new_coord, velocity, step_end, output ready);
endinterface

// ===== sv/bdfmv_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read-first output.
module bdfmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bdfmv_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts items, tracks the step ring, and reads and writes the history.
module bdfmv_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bdfmv_in_if.sink                      in_i,
  input  logic [1:0]                    order_i,
  input  logic [bdfmv_pkg::QCNT_W-1:0]  q_count_i,
  output bdfmv_pkg::push_t              push_o
);

  logic                                  accept;
  logic                                  in_range;
  logic [bdfmv_pkg::IDX_W-1:0]           idx;
  logic [31:0]                           sum;
  logic [2:0]                            ord_req;
  logic [2:0]                            ord_lim;
  logic [2:0]                            ord_sel;
  logic [bdfmv_pkg::SLOT_W-1:0]          wslot;
  logic [bdfmv_pkg::SLOT_W-1:0]          head_d, head_q;
  logic [1:0]                            steps_d, steps_q;
  logic [bdfmv_pkg::MAX_ORDER-1:0]       use_d, use_q;
  logic [bdfmv_pkg::MAX_ORDER-1:0][bdfmv_pkg::SLOT_W-1:0] slot_d, slot_q;
  logic [bdfmv_pkg::SLOT_W+1:0]          slot_sum [bdfmv_pkg::MAX_ORDER];
  logic [bdfmv_pkg::HISTORY-1:0][31:0]   rd_data;
  logic                                  f_valid_q;
  logic signed [31:0]                    coord_q;
  logic signed [31:0]                    rest_q;
  logic [1:0]                            ord_q;
  logic                                  last_q;

  // Room is counted against the queue plus the item waiting on its history read.
  assign in_i.ready = ({1'b0, q_count_i} + (bdfmv_pkg::QCNT_W + 1)'(f_valid_q))
                      < (bdfmv_pkg::QCNT_W + 1)'(bdfmv_pkg::QDEPTH);
  assign accept = in_i.valid & in_i.ready;

  assign in_range = (32'(in_i.point_index) < bdfmv_pkg::POINTS)
                  && (32'(in_i.axis) < bdfmv_pkg::AXES);
  assign idx = bdfmv_pkg::IDX_W'(32'(in_i.point_index) * bdfmv_pkg::AXES
                                 + 32'(in_i.axis));
  assign sum = in_i.rest_coord + in_i.displacement;

  // The slot written this step becomes lag zero of the next step.
  assign wslot = (head_q == '0) ? bdfmv_pkg::SLOT_W'(bdfmv_pkg::HISTORY - 1)
                                : head_q - 1'b1;

  always_comb begin
    ord_req = (order_i == 2'd0) ? 3'd1 : {1'b0, order_i};
    ord_lim = {1'b0, steps_q} + 3'd1;
    ord_sel = (ord_req > ord_lim) ? ord_lim : ord_req;
    if (ord_sel > 3'(bdfmv_pkg::HISTORY)) begin
      ord_sel = 3'(bdfmv_pkg::HISTORY);
    end
    // Only lags inside the chosen order are taken from the history.
    for (int j = 0; j < bdfmv_pkg::MAX_ORDER; j++) begin
      slot_sum[j] = (bdfmv_pkg::SLOT_W + 2)'(head_q) + (bdfmv_pkg::SLOT_W + 2)'(j);
      if (slot_sum[j] >= (bdfmv_pkg::SLOT_W + 2)'(bdfmv_pkg::HISTORY)) begin
        slot_sum[j] = slot_sum[j] - (bdfmv_pkg::SLOT_W + 2)'(bdfmv_pkg::HISTORY);
      end
      slot_d[j] = bdfmv_pkg::SLOT_W'(slot_sum[j]);
      use_d[j]  = in_range && (32'(steps_q) > j) && (j < int'(ord_sel))
                  && (j < bdfmv_pkg::HISTORY);
    end
    head_d  = head_q;
    steps_d = steps_q;
    if (accept && in_i.last_in_step) begin
      head_d = wslot;
      if (steps_q != 2'd3) begin
        steps_d = steps_q + 2'd1;
      end
    end
  end

  for (genvar s = 0; s < bdfmv_pkg::HISTORY; s++) begin : g_slot
    bdfmv_ram #(
      .WIDTH (32),
      .DEPTH (bdfmv_pkg::ENTRIES)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (accept && in_range && (wslot == bdfmv_pkg::SLOT_W'(s))),
      .waddr_i (idx),
      .wdata_i (sum),
      .re_i    (accept),
      .raddr_i (idx),
      .rdata_o (rd_data[s])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      head_q    <= '0;
      steps_q   <= '0;
    end else begin
      f_valid_q <= accept;
      head_q    <= head_d;
      steps_q   <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      coord_q <= sum;
      rest_q  <= in_i.rest_coord;
      ord_q   <= ord_sel[1:0];
      last_q  <= in_i.last_in_step;
      use_q   <= use_d;
      slot_q  <= slot_d;
    end
  end

  always_comb begin
    push_o.valid      = f_valid_q;
    push_o.item.coord = coord_q;
    push_o.item.ord   = ord_q;
    push_o.item.last  = last_q;
    for (int j = 0; j < bdfmv_pkg::MAX_ORDER; j++) begin
      push_o.item.lag[j] = use_q[j] ? rd_data[slot_q[j]] : rest_q;
    end
  end

endmodule

// ===== sv/bdfmv_queue.sv =====
`timescale 1ns / 1ps
// Short queue of classified items between the front end and the arithmetic back end.
module bdfmv_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bdfmv_pkg::push_t              push_i,
  input  logic                          pop_i,
  output logic [bdfmv_pkg::QCNT_W-1:0]  count_o,
  output logic                          avail_o,
  output bdfmv_pkg::item_t              item_o
);

  bdfmv_pkg::item_t                 store_q [bdfmv_pkg::QDEPTH];
  logic [bdfmv_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
  logic [bdfmv_pkg::QCNT_W-1:0]     count_q;

  // The front end never pushes without room, so no full check is needed here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i.valid) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      count_q <= count_q + bdfmv_pkg::QCNT_W'(push_i.valid)
                         - bdfmv_pkg::QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      store_q[wptr_q] <= push_i.item;
    end
  end

  assign count_o = count_q;
  assign avail_o = (count_q != '0);
  assign item_o  = store_q[rptr_q];

endmodule

// ===== sv/bdfmv_back.sv =====
`timescale 1ns / 1ps
// Back end: weighted difference, timestep scaling, saturation and result register.
module bdfmv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bdfmv_pkg::item_t  item_i,
  input  logic              avail_i,
  output logic              pop_o,
  input  logic [31:0]       inv_i,
  bdfmv_out_if.source       out_o
);

  localparam int MO = bdfmv_pkg::MAX_ORDER;

  logic                                  adv;
  logic [1:0]                            om1;
  logic signed [bdfmv_pkg::PROD_W-1:0]   p_d [MO+1];
  logic signed [bdfmv_pkg::PROD_W-1:0]   p_q [MO+1];
  logic signed [bdfmv_pkg::ACC_W-1:0]    acc;
  logic signed [bdfmv_pkg::D_W-1:0]      d_q;
  logic signed [16:0]                    inv_hi, inv_lo;
  logic signed [bdfmv_pkg::MUL_W-1:0]    mhi_q, mlo_q;
  logic signed [bdfmv_pkg::SUM_W-1:0]    vsum;
  logic signed [bdfmv_pkg::V_W-1:0]      v_q;
  logic signed [31:0]                    vel;
  logic [3:0]                            valid_q;
  logic signed [31:0]                    coord_q [4];
  logic [3:0]                            last_q;
  logic                                  out_valid_q;
  logic signed [31:0]                    new_coord_q;
  logic signed [31:0]                    velocity_q;
  logic                                  step_end_q;

  // The whole pipeline moves together whenever the result register can take a value.
  assign adv   = !out_valid_q || out_o.ready;
  assign pop_o = adv && avail_i;

  assign om1 = item_i.ord - 2'd1;

  always_comb begin
    p_d[0] = bdfmv_pkg::PROD_W'(bdfmv_pkg::GAMMA_Q14[om1])
           * bdfmv_pkg::PROD_W'(item_i.coord);
    for (int j = 0; j < MO; j++) begin
      p_d[j+1] = bdfmv_pkg::PROD_W'(bdfmv_pkg::ALPHA_Q14[om1][j])
               * bdfmv_pkg::PROD_W'($signed(item_i.lag[j]));
    end
  end

  // Round the Q.30 difference to Q16.16 with a floor shift.
  always_comb begin
    acc = bdfmv_pkg::ACC_W'(p_q[0])
        + bdfmv_pkg::ACC_W'(1 << (bdfmv_pkg::COEF_FRAC - 1));
    for (int j = 1; j <= MO; j++) begin
      acc = acc - bdfmv_pkg::ACC_W'(p_q[j]);
    end
  end

  assign inv_hi = $signed({1'b0, inv_i[31:16]});
  assign inv_lo = $signed({1'b0, inv_i[15:0]});

  assign vsum = (bdfmv_pkg::SUM_W'(mhi_q) <<< bdfmv_pkg::VEL_FRAC)
              + bdfmv_pkg::SUM_W'(mlo_q)
              + bdfmv_pkg::SUM_W'(1 << (bdfmv_pkg::VEL_FRAC - 1));

  always_comb begin
    if (v_q > bdfmv_pkg::V_W'(bdfmv_pkg::S32_MAX)) begin
      vel = bdfmv_pkg::S32_MAX;
    end else if (v_q < bdfmv_pkg::V_W'(bdfmv_pkg::S32_MIN)) begin
      vel = bdfmv_pkg::S32_MIN;
    end else begin
      vel = v_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      valid_q     <= {valid_q[2:0], avail_i};
      out_valid_q <= valid_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q          <= p_d;
      coord_q[0]   <= item_i.coord;
      last_q[0]    <= item_i.last;
      d_q          <= acc[bdfmv_pkg::ACC_W-1:bdfmv_pkg::COEF_FRAC];
      mhi_q        <= bdfmv_pkg::MUL_W'(d_q) * bdfmv_pkg::MUL_W'(inv_hi);
      mlo_q        <= bdfmv_pkg::MUL_W'(d_q) * bdfmv_pkg::MUL_W'(inv_lo);
      v_q          <= vsum[bdfmv_pkg::SUM_W-1:bdfmv_pkg::VEL_FRAC];
      for (int s = 1; s < 4; s++) begin
        coord_q[s] <= coord_q[s-1];
        last_q[s]  <= last_q[s-1];
      end
      new_coord_q  <= coord_q[3];
      step_end_q   <= last_q[3];
      velocity_q   <= vel;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.new_coord = new_coord_q;
  assign out_o.velocity  = velocity_q;
  assign out_o.step_end  = step_end_q;

endmodule

// ===== sv/bdf_mesh_velocity_unit.sv =====
`timescale 1ns / 1ps
// Top level of the backward-difference mesh coordinate velocity unit.
//
//   Port group   Direction  Transaction
//   in_i         sink       one mesh point and axis: index, rest coordinate, displacement
//   out_o        source     new coordinate, saturated velocity, end-of-step flag
//   APB (psel..) slave      register 0 bdf_order at byte 0, register 1 inv_timestep at 4
//
// The unit takes one transaction per cycle while out_o does not stall and returns one result
// per transaction, in order, through the history RAM read, the queue, the multiply and round
// stages and the result register. Reset clears the step counter, the ring position and the
// pipeline; the history RAMs are not cleared, and the user must see that an entry is only
// read after an earlier step has written it; the block does not enforce this. When out_o
// stalls, the back end holds and the four-entry queue fills; in_i.ready drops once the
// queue and the item waiting on its history read take all four entries.
//
// The front end accepts a transaction, forms the new coordinate, chooses the difference
// order from the start-up ramp, and in the same cycle reads all ring slots of the point
// and writes the new coordinate into the slot that becomes lag zero at the end of the
// step. RAM reads return the old contents on a same-address write, so every item sees
// exactly the history left by the items before it without any forwarding.
module bdf_mesh_velocity_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bdfmv_in_if.sink                      in_i,
  bdfmv_out_if.source                   out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bdfmv_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [1:0]                         order_q;
  logic [31:0]                        inv_q;
  logic                               cfg_write;
  bdfmv_pkg::reg_idx_e                reg_idx;
  bdfmv_pkg::push_t                   push;
  logic                               pop;
  logic [bdfmv_pkg::QCNT_W-1:0]       q_count;
  logic                               q_avail;
  bdfmv_pkg::item_t                   q_item;

  // Registers are one word apart; the word address selects the register.
  assign pready    = 1'b1;
  assign reg_idx   = bdfmv_pkg::reg_idx_e'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 2'd1;
      inv_q   <= 32'd65536;
    end else if (cfg_write) begin
      case (reg_idx)
        bdfmv_pkg::REG_BDF_ORDER:    order_q <= pwdata[1:0];
        bdfmv_pkg::REG_INV_TIMESTEP: inv_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bdfmv_pkg::REG_BDF_ORDER:    prdata = {30'd0, order_q};
      bdfmv_pkg::REG_INV_TIMESTEP: prdata = inv_q;
      default:                     prdata = '0;
    endcase
  end

  bdfmv_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .order_i   (order_q),
    .q_count_i (q_count),
    .push_o    (push)
  );

  bdfmv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .count_o (q_count),
    .avail_o (q_avail),
    .item_o  (q_item)
  );

  bdfmv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (q_item),
    .avail_i (q_avail),
    .pop_o   (pop),
    .inv_i   (inv_q),
    .out_o   (out_o)
  );

endmodule

// ===== bench/bdf_mesh_velocity_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the mesh velocity unit with a predicting scoreboard.
module bdf_mesh_velocity_unit_test;

  // The backward difference tables in Q2.14, indexed by the order minus one.
  localparam longint GAMMA_T [3] = '{16384, 24576, 30037};
  localparam longint ALPHA_T [3][3] = '{
    '{16384, 0, 0},
    '{32768, -8192, 0},
    '{49152, -24576, 5461}
  };

  localparam logic [1:0] AXIS_X   = 2'd0;
  localparam logic [1:0] AXIS_Y   = 2'd1;
  localparam logic [1:0] AXIS_Z   = 2'd2;
  localparam logic [1:0] AXIS_OFF = 2'd3;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  localparam int unsigned POOL       = 24;
  localparam int unsigned PHASES     = 12;
  localparam int unsigned PHASE_LEN  = 150;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned SETTLE     = 10;
  localparam int unsigned IDLE_LIMIT = 20000;

  localparam logic [1:0]  ORDER_TAB [6] = '{2'd0, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2};
  localparam logic [31:0] INV_TAB   [5] = '{32'h0000_0000, 32'h0001_0000, 32'h0000_0001,
                                            32'hFFFF_FFFF, 32'h0000_8000};

  typedef struct {
    logic [31:0] coord;
    logic [31:0] vel;
    logic        last;
  } velocity_result_t;

  // The scoreboard keeps its own copy of the coordinate ring, the step counter and the
  // registers, predicts each result when its transaction is accepted, and checks results
  // in order against the queue of predictions.
  class bdf_velocity_scoreboard;
    velocity_result_t expected_q [$];
    logic [31:0]      coord_ring [bdfmv_pkg::ENTRIES][bdfmv_pkg::HISTORY];
    bit               ring_written [bdfmv_pkg::ENTRIES][bdfmv_pkg::HISTORY];
    int unsigned      steps_ended;
    int unsigned      ring_head;
    logic [1:0]       order_reg;
    logic [31:0]      inv_step_reg;
    int unsigned      errors;

    function new();
      steps_ended  = 0;
      ring_head    = 0;
      order_reg    = 2'd1;
      inv_step_reg = 32'h0001_0000;
      errors       = 0;
    endfunction

    function void set_register(bdfmv_pkg::reg_idx_e r, logic [31:0] value);
      if (r == bdfmv_pkg::REG_BDF_ORDER) begin
        order_reg = value[1:0];
      end else begin
        inv_step_reg = value;
      end
    endfunction

    // Order after the start-up ramp; a zero order register acts as first order.
    function int unsigned active_order();
      int unsigned ord;
      ord = (order_reg == 2'd0) ? 1 : order_reg;
      if (ord > steps_ended + 1) ord = steps_ended + 1;
      if (ord > bdfmv_pkg::HISTORY) ord = bdfmv_pkg::HISTORY;
      return ord;
    endfunction

    // True when every history slot that this point and axis would read has been written.
    function bit history_ready(int unsigned p, int unsigned a);
      int unsigned idx;
      int unsigned depth;
      int unsigned j;
      if (p >= bdfmv_pkg::POINTS || a >= bdfmv_pkg::AXES) return 1'b1;
      idx   = p * bdfmv_pkg::AXES + a;
      depth = active_order();
      if (depth > steps_ended) depth = steps_ended;
      for (j = 0; j < depth; j++) begin
        if (!ring_written[idx][(ring_head + j) % bdfmv_pkg::HISTORY]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_input(logic [11:0] p, logic [1:0] a, logic [31:0] rest,
                             logic [31:0] disp, logic last);
      velocity_result_t r;
      logic [31:0]      sum;
      longint           rest_s;
      longint           coord_s;
      longint           lag;
      longint           acc;
      longint           d;
      longint           v;
      longint           hi;
      longint           lo;
      bit               in_range;
      int unsigned      idx;
      int unsigned      ord;
      int unsigned      j;
      sum      = rest + disp;
      rest_s   = longint'($signed(rest));
      coord_s  = longint'($signed(sum));
      in_range = (p < bdfmv_pkg::POINTS) && (a < bdfmv_pkg::AXES);
      idx      = in_range ? p * bdfmv_pkg::AXES + a : 0;
      ord      = active_order();

      acc = GAMMA_T[ord-1] * coord_s;
      for (j = 0; j < ord; j++) begin
        lag = rest_s;
        if (in_range && j < steps_ended) begin
          lag = longint'($signed(coord_ring[idx][(ring_head + j) % bdfmv_pkg::HISTORY]));
        end
        acc -= ALPHA_T[ord-1][j] * lag;
      end
      d  = (acc + 8192) >>> 14;
      hi = longint'(inv_step_reg[31:16]);
      lo = longint'(inv_step_reg[15:0]);
      v  = d * hi + ((d * lo + 32768) >>> 16);
      if (v > longint'($signed(Q_MAX))) v = longint'($signed(Q_MAX));
      if (v < longint'($signed(Q_MIN))) v = longint'($signed(Q_MIN));

      // The new coordinate goes to the slot that turns into lag zero at the step end.
      if (in_range) begin
        coord_ring[idx][(ring_head + bdfmv_pkg::HISTORY - 1) % bdfmv_pkg::HISTORY]   = sum;
        ring_written[idx][(ring_head + bdfmv_pkg::HISTORY - 1) % bdfmv_pkg::HISTORY] = 1'b1;
      end
      if (last) begin
        ring_head = (ring_head + bdfmv_pkg::HISTORY - 1) % bdfmv_pkg::HISTORY;
        if (steps_ended < 3) steps_ended++;
      end

      r.coord = sum;
      r.vel   = v[31:0];
      r.last  = last;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(logic [31:0] coord, logic [31:0] vel, logic last);
      velocity_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing pending, new_coord %h velocity %h step_end %b",
                 $time, coord, vel, last);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (coord !== exp_r.coord) begin
        $display("%0t: new_coord expected %h actual %h", $time, exp_r.coord, coord);
        errors++;
      end
      if (vel !== exp_r.vel) begin
        $display("%0t: velocity expected %h actual %h", $time, exp_r.vel, vel);
        errors++;
      end
      if (last !== exp_r.last) begin
        $display("%0t: step_end expected %b actual %b", $time, exp_r.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [bdfmv_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  bdfmv_in_if  in_bus ();
  bdfmv_out_if out_bus ();

  bdf_mesh_velocity_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bdf_velocity_scoreboard sb = new();

  // Idle rates in percent for the sender and the receiver, and the length of a forced
  // receiver hold-off, which the receiver process counts down on its own.
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_left    = 0;
  int unsigned items_sent   = 0;

  // A fixed working set of mesh points and axes. All of them are written in the first
  // step after reset, so later steps only read history that exists.
  logic [11:0] pool_point [POOL];
  logic [1:0]  pool_axis  [POOL];
  logic [31:0] pool_rest  [POOL];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Monitor and watchdog. Handshakes are sampled at the falling edge, where valid and
  // ready are settled for the rising edge that completes the transaction. The run fails
  // when no transaction completes on either channel for too long.
  initial begin : monitor
    int unsigned idle_cycles;
    bit          in_fire;
    bit          out_fire;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      if (rst_ni) begin
        in_fire  = in_bus.valid && in_bus.ready;
        out_fire = out_bus.valid && out_bus.ready;
        if (in_fire) begin
          sb.note_input(in_bus.point_index, in_bus.axis, in_bus.rest_coord,
                        in_bus.displacement, in_bus.last_in_step);
        end
        if (out_fire) begin
          sb.check_result(out_bus.new_coord, out_bus.velocity, out_bus.step_end);
        end
        idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
      end
    end
    $display("FAILURE");
    $finish;
  end

  // Mostly small displacements keep the velocity in range; the rest are full width.
  function automatic logic [31:0] next_displacement();
    if ($urandom_range(99) < 80) begin
      return $urandom_range(32'h0007_FFFF) - 32'h0004_0000;
    end
    return $urandom;
  endfunction

  // APB write with a setup and an access phase; the register takes the value at the edge that ends the access.
  task automatic cfg_write(input bdfmv_pkg::reg_idx_e r, input logic [31:0] value);
    logic [bdfmv_pkg::PADDR_W-1:0] addr;
    addr = bdfmv_pkg::PADDR_W'(4 * int'(r));
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(r, value);
  endtask

  // Offers one transaction and returns at the edge that accepts it. A point whose
  // history would be read before it was ever written is sent on the unused axis code,
  // which the block treats as out of range.
  task automatic drive_item(input logic [11:0] p, input logic [1:0] a,
                            input logic [31:0] rest, input logic [31:0] disp,
                            input logic last);
    logic [1:0] axis_sent;
    axis_sent = a;
    if (!sb.history_ready(p, a)) axis_sent = AXIS_OFF;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.point_index  <= p;
    in_bus.axis         <= axis_sent;
    in_bus.rest_coord   <= rest;
    in_bus.displacement <= disp;
    in_bus.last_in_step <= last;
    @(negedge clk);
    while (!in_bus.ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  // Stops offering and waits until every predicted result has been checked.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Well-formed time steps over the working set in random order, with some noise items,
  // skipped points and steps cut short.
  task automatic run_phase(input int unsigned count);
    int unsigned perm [POOL];
    int unsigned start;
    int unsigned i;
    int unsigned k;
    int unsigned tmp;
    bit          cut;
    start = items_sent;
    while (items_sent - start < count) begin
      for (i = 0; i < POOL; i++) perm[i] = i;
      for (i = POOL - 1; i > 0; i--) begin
        k       = $urandom_range(i);
        tmp     = perm[i];
        perm[i] = perm[k];
        perm[k] = tmp;
      end
      cut = 1'b0;
      for (i = 0; i < POOL && !cut && items_sent - start < count; i++) begin
        k = perm[i];
        if ($urandom_range(99) < 5) begin
          if ($urandom_range(1) == 0) begin
            drive_item(12'($urandom_range(4095)), 2'($urandom_range(3)), $urandom,
                       $urandom, $urandom_range(19) == 0);
          end else begin
            tmp = $urandom_range(POOL - 1);
            drive_item(pool_point[tmp], pool_axis[tmp], pool_rest[tmp],
                       next_displacement(), 1'b0);
          end
        end
        if ($urandom_range(99) < 10) pool_rest[k] = $urandom;
        if ($urandom_range(99) >= 3) begin
          cut = ($urandom_range(199) == 0);
          drive_item(pool_point[k], pool_axis[k], pool_rest[k], next_displacement(),
                     cut || (i == POOL - 1));
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [31:0] ext_rest [6];
    logic [31:0] ext_disp [6];
    logic [31:0] inv_val;
    logic [1:0]  order_val;
    int unsigned ph;
    int unsigned k;

    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.point_index  <= '0;
    in_bus.axis         <= AXIS_X;
    in_bus.rest_coord   <= '0;
    in_bus.displacement <= '0;
    in_bus.last_in_step <= 1'b0;

    // The first six pool entries cover the extreme indexes on every axis.
    pool_point[0] = 12'd0;    pool_axis[0] = AXIS_X;
    pool_point[1] = 12'd0;    pool_axis[1] = AXIS_Y;
    pool_point[2] = 12'd0;    pool_axis[2] = AXIS_Z;
    pool_point[3] = 12'd4095; pool_axis[3] = AXIS_X;
    pool_point[4] = 12'd4095; pool_axis[4] = AXIS_Y;
    pool_point[5] = 12'd4095; pool_axis[5] = AXIS_Z;
    for (k = 6; k < POOL; k++) begin
      pool_point[k] = 12'($urandom_range(1, 4094));
      pool_axis[k]  = 2'($urandom_range(2));
    end

    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed part, all in the first step after reset. A huge inverse time step drives
    // the velocity into saturation both ways; the sums wrap at both ends; two items use
    // the unused axis code.
    cfg_write(bdfmv_pkg::REG_BDF_ORDER, 32'd3);
    cfg_write(bdfmv_pkg::REG_INV_TIMESTEP, 32'hFFFF_FFFF);
    ext_rest = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, 32'h0, 32'h0};
    ext_disp = '{32'h0, 32'h0, 32'h1, 32'hFFFF_FFFF, Q_MAX, Q_MIN};
    for (k = 0; k < 6; k++) begin
      pool_rest[k] = ext_rest[k];
      drive_item(pool_point[k], pool_axis[k], ext_rest[k], ext_disp[k], 1'b0);
    end
    drive_item(12'd4095, AXIS_OFF, Q_MAX, Q_MAX, 1'b0);
    drive_item(12'd0, AXIS_OFF, Q_MIN, Q_MIN, 1'b0);
    for (k = 6; k < POOL; k++) begin
      pool_rest[k] = $urandom;
      drive_item(pool_point[k], pool_axis[k], pool_rest[k], next_displacement(),
                 k == POOL - 1);
    end
    drain();

    // Random phases. Both registers are rewritten at each idle boundary; the early
    // phases take the extreme settings, among them order zero and a zero time step.
    for (ph = 0; ph < PHASES; ph++) begin
      order_val = (ph < 6) ? ORDER_TAB[ph] : 2'($urandom_range(3));
      if (ph < 5) begin
        inv_val = INV_TAB[ph];
      end else begin
        case ($urandom_range(3))
          0: inv_val = $urandom;
          1: inv_val = $urandom_range(1, 32'h0004_0000);
          2: inv_val = 32'h0001_0000 * $urandom_range(1, 16);
          default: inv_val = 32'hFFFF_FFFF;
        endcase
      end
      cfg_write(bdfmv_pkg::REG_BDF_ORDER, {30'd0, order_val});
      cfg_write(bdfmv_pkg::REG_INV_TIMESTEP, inv_val);
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
        default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
      endcase
      // With the sender never idle, a long receiver hold-off fills the block and
      // pushes back on the input channel.
      if (ph == 4 || ph == 8) hold_left = HOLD_LEN;
      run_phase(PHASE_LEN);
      drain();
    end

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bdfmv_pkg.sv
sv/bdfmv_if.sv
sv/bdfmv_ram.sv
sv/bdfmv_front.sv
sv/bdfmv_queue.sv
sv/bdfmv_back.sv
sv/bdf_mesh_velocity_unit.sv
bench/bdf_mesh_velocity_unit_test.sv
